@@ hdl/ctss_pkg.sv @@
// Shared types, token codes and character constants of the C subset token scanner.
package ctss_pkg;

	localparam int DEF_LEXEME_CHARS = 8;
	localparam int DEF_COUNTER_BITS = 16;
	localparam int DEF_QUEUE_DEPTH  = 4;

	localparam logic [4:0] TK_END        = 5'd0;
	localparam logic [4:0] TK_ERROR      = 5'd1;
	localparam logic [4:0] TK_INT_CONST  = 5'd2;
	localparam logic [4:0] TK_CHAR_CONST = 5'd3;
	localparam logic [4:0] TK_IDENT      = 5'd4;
	localparam logic [4:0] TK_KW_INT     = 5'd5;
	localparam logic [4:0] TK_KW_DOUBLE  = 5'd6;
	localparam logic [4:0] TK_KW_FOR     = 5'd7;
	localparam logic [4:0] TK_KW_RETURN  = 5'd8;
	localparam logic [4:0] TK_GE         = 5'd9;
	localparam logic [4:0] TK_GT         = 5'd10;
	localparam logic [4:0] TK_LE         = 5'd11;
	localparam logic [4:0] TK_LT         = 5'd12;
	localparam logic [4:0] TK_EQ         = 5'd13;
	localparam logic [4:0] TK_ASSIGN     = 5'd14;
	localparam logic [4:0] TK_INC        = 5'd15;
	localparam logic [4:0] TK_PLUS       = 5'd16;
	localparam logic [4:0] TK_DEC        = 5'd17;
	localparam logic [4:0] TK_MINUS      = 5'd18;
	localparam logic [4:0] TK_NE         = 5'd19;
	localparam logic [4:0] TK_NOT        = 5'd20;
	localparam logic [4:0] TK_COMMA      = 5'd21;
	localparam logic [4:0] TK_SEMI       = 5'd22;
	localparam logic [4:0] TK_LPAREN     = 5'd23;
	localparam logic [4:0] TK_RPAREN     = 5'd24;
	localparam logic [4:0] TK_LBRACE     = 5'd25;
	localparam logic [4:0] TK_RBRACE     = 5'd26;
	localparam logic [4:0] TK_LBRACKET   = 5'd27;
	localparam logic [4:0] TK_RBRACKET   = 5'd28;
	localparam logic [4:0] TK_STAR       = 5'd29;
	localparam logic [4:0] TK_SLASH      = 5'd30;
	localparam logic [4:0] TK_PERCENT    = 5'd31;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_QUOTE    = 8'h27;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_DIGIT_0  = 8'h30;
	localparam logic [7:0] CH_DIGIT_9  = 8'h39;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_LT       = 8'h3C;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_GT       = 8'h3E;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_UNDER    = 8'h5F;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	localparam logic [63:0] KW_INT_TEXT    = 64'h0000_0000_0074_6E69;
	localparam logic [63:0] KW_DOUBLE_TEXT = 64'h0000_656C_6275_6F64;
	localparam logic [63:0] KW_FOR_TEXT    = 64'h0000_0000_0072_6F66;
	localparam logic [63:0] KW_RETURN_TEXT = 64'h0000_6E72_7574_6572;
	localparam logic [3:0]  KW_SHORT_LEN   = 4'd3;
	localparam logic [3:0]  KW_LONG_LEN    = 4'd6;

	typedef enum logic [12:0] {
		M_IDLE    = 13'b0_0000_0000_0001,
		M_NUMBER  = 13'b0_0000_0000_0010,
		M_NUMBAD  = 13'b0_0000_0000_0100,
		M_CHOPEN  = 13'b0_0000_0000_1000,
		M_CHESC   = 13'b0_0000_0001_0000,
		M_CHCLOSE = 13'b0_0000_0010_0000,
		M_IDENT   = 13'b0_0000_0100_0000,
		M_IDLONG  = 13'b0_0000_1000_0000,
		M_PAIR    = 13'b0_0001_0000_0000,
		M_SLASH   = 13'b0_0010_0000_0000,
		M_COMMENT = 13'b0_0100_0000_0000,
		M_ENDED   = 13'b0_1000_0000_0000,
		M_HALTED  = 13'b1_0000_0000_0000
	} scan_mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [63:0] text;
		logic [3:0]  len;
		logic [15:0] line;
		logic [15:0] col;
	} token_t;

	typedef struct packed {
		logic   two;
		token_t first;
		token_t second;
	} bundle_t;

endpackage

@@ hdl/ctss_front.sv @@
// Front end: accepts text bytes, runs the scan state and builds token bundles.
module ctss_front #(
	parameter int LEXEME_CHARS = ctss_pkg::DEF_LEXEME_CHARS,
	parameter int COUNTER_BITS = ctss_pkg::DEF_COUNTER_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	output logic              push,
	output ctss_pkg::bundle_t push_data,
	input  logic              full
);

	localparam int LW = 8 * LEXEME_CHARS;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= ctss_pkg::CH_DIGIT_0) && (b <= ctss_pkg::CH_DIGIT_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= ctss_pkg::CH_LOWER_A) && (b <= ctss_pkg::CH_LOWER_Z)) ||
			((b >= ctss_pkg::CH_UPPER_A) && (b <= ctss_pkg::CH_UPPER_Z));
	endfunction

	function automatic logic is_pair_first(input logic [7:0] b);
		return (b == ctss_pkg::CH_GT) || (b == ctss_pkg::CH_LT) || (b == ctss_pkg::CH_EQUALS) ||
			(b == ctss_pkg::CH_PLUS) || (b == ctss_pkg::CH_MINUS) || (b == ctss_pkg::CH_BANG);
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] b);
		logic [4:0] k;
		unique case (b)
			ctss_pkg::CH_COMMA:    k = ctss_pkg::TK_COMMA;
			ctss_pkg::CH_SEMI:     k = ctss_pkg::TK_SEMI;
			ctss_pkg::CH_LPAREN:   k = ctss_pkg::TK_LPAREN;
			ctss_pkg::CH_RPAREN:   k = ctss_pkg::TK_RPAREN;
			ctss_pkg::CH_LBRACE:   k = ctss_pkg::TK_LBRACE;
			ctss_pkg::CH_RBRACE:   k = ctss_pkg::TK_RBRACE;
			ctss_pkg::CH_LBRACKET: k = ctss_pkg::TK_LBRACKET;
			ctss_pkg::CH_RBRACKET: k = ctss_pkg::TK_RBRACKET;
			ctss_pkg::CH_STAR:     k = ctss_pkg::TK_STAR;
			ctss_pkg::CH_PERCENT:  k = ctss_pkg::TK_PERCENT;
			default:               k = ctss_pkg::TK_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] pair_kind(input logic [7:0] first, input logic two);
		logic [4:0] k;
		unique case (first)
			ctss_pkg::CH_GT:     k = two ? ctss_pkg::TK_GE  : ctss_pkg::TK_GT;
			ctss_pkg::CH_LT:     k = two ? ctss_pkg::TK_LE  : ctss_pkg::TK_LT;
			ctss_pkg::CH_EQUALS: k = two ? ctss_pkg::TK_EQ  : ctss_pkg::TK_ASSIGN;
			ctss_pkg::CH_PLUS:   k = two ? ctss_pkg::TK_INC : ctss_pkg::TK_PLUS;
			ctss_pkg::CH_MINUS:  k = two ? ctss_pkg::TK_DEC : ctss_pkg::TK_MINUS;
			default:             k = two ? ctss_pkg::TK_NE  : ctss_pkg::TK_NOT;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] ident_kind(input logic [63:0] text, input logic [3:0] len);
		logic [4:0] k;
		k = ctss_pkg::TK_IDENT;
		if (len == ctss_pkg::KW_SHORT_LEN && text == ctss_pkg::KW_INT_TEXT)
			k = ctss_pkg::TK_KW_INT;
		else if (len == ctss_pkg::KW_LONG_LEN && text == ctss_pkg::KW_DOUBLE_TEXT)
			k = ctss_pkg::TK_KW_DOUBLE;
		else if (len == ctss_pkg::KW_SHORT_LEN && text == ctss_pkg::KW_FOR_TEXT)
			k = ctss_pkg::TK_KW_FOR;
		else if (len == ctss_pkg::KW_LONG_LEN && text == ctss_pkg::KW_RETURN_TEXT)
			k = ctss_pkg::TK_KW_RETURN;
		return k;
	endfunction

	function automatic ctss_pkg::token_t mk_tok(
		input logic [4:0]              kind,
		input logic [63:0]             text,
		input logic [3:0]              len,
		input logic [COUNTER_BITS-1:0] ln,
		input logic [COUNTER_BITS-1:0] cl
	);
		ctss_pkg::token_t t;
		t.kind = kind;
		t.text = text;
		t.len  = len;
		t.line = 16'(ln);
		t.col  = 16'(cl);
		return t;
	endfunction

	ctss_pkg::scan_mode_t      mode_q, mode_d, idle_mode;
	logic [LW-1:0]             buf_q, buf_d, idle_buf, buf_add, buf_drop;
	logic [3:0]                cnt_q, cnt_d, idle_cnt, cnt_add, cnt_drop;
	logic [COUNTER_BITS-1:0]   line_q, line_d, idle_line, line_inc;
	logic [COUNTER_BITS-1:0]   col_q, col_d, idle_col, col_inc1, col_inc8;
	logic [COUNTER_BITS:0]     col_sum1, col_sum8;
	logic                      add_ok, accept, emit0, rescan, idle_emit;
	logic [7:0]                pair_first, pair_second;
	logic [63:0]               cur_text;
	ctss_pkg::token_t          tok0, idle_tok;

	assign accept   = in_valid && !full;
	assign in_stall = full;
	assign cur_text = 64'(buf_q);

	assign col_sum1 = {1'b0, col_q} + (COUNTER_BITS+1)'(1);
	assign col_sum8 = {1'b0, col_q} + (COUNTER_BITS+1)'(8);
	assign col_inc1 = col_sum1[COUNTER_BITS] ? CNT_MAX : col_sum1[COUNTER_BITS-1:0];
	assign col_inc8 = col_sum8[COUNTER_BITS] ? CNT_MAX : col_sum8[COUNTER_BITS-1:0];
	assign line_inc = (line_q == CNT_MAX) ? line_q : line_q + COUNTER_BITS'(1);

	assign add_ok   = cnt_q < 4'(LEXEME_CHARS);
	assign cnt_add  = add_ok ? cnt_q + 4'd1 : cnt_q;
	assign cnt_drop = (cnt_q == 4'd0) ? 4'd0 : cnt_q - 4'd1;

	assign pair_first  = buf_q[7:0];
	assign pair_second = (pair_first == ctss_pkg::CH_PLUS || pair_first == ctss_pkg::CH_MINUS) ?
		pair_first : ctss_pkg::CH_EQUALS;

	always_comb begin
		buf_add  = buf_q;
		buf_drop = buf_q;
		for (int i = 0; i < LEXEME_CHARS; i++) begin
			if (cnt_q == 4'(i))
				buf_add[8*i +: 8] = char_code;
			if (cnt_q == 4'(i + 1))
				buf_drop[8*i +: 8] = 8'h00;
		end
	end

	// Scan of a byte from the state between tokens.
	always_comb begin
		idle_mode = ctss_pkg::M_IDLE;
		idle_buf  = buf_q;
		idle_cnt  = cnt_q;
		idle_line = line_q;
		idle_col  = col_q;
		idle_emit = 1'b0;
		idle_tok  = mk_tok(ctss_pkg::TK_END, '0, '0, line_q, col_q);
		if (char_code == ctss_pkg::CH_NUL) begin
			idle_mode = ctss_pkg::M_ENDED;
			idle_emit = 1'b1;
		end else if (char_code == ctss_pkg::CH_SPACE) begin
			idle_col = col_inc1;
		end else if (char_code == ctss_pkg::CH_TAB) begin
			idle_col = col_inc8;
		end else if (char_code == ctss_pkg::CH_NL) begin
			idle_line = line_inc;
			idle_col  = '0;
		end else begin
			idle_col = col_inc1;
			idle_buf = (char_code == ctss_pkg::CH_QUOTE) ? '0 : LW'(char_code);
			idle_cnt = (char_code == ctss_pkg::CH_QUOTE) ? 4'd0 : 4'd1;
			if (is_digit(char_code)) begin
				idle_mode = ctss_pkg::M_NUMBER;
			end else if (is_letter(char_code)) begin
				idle_mode = ctss_pkg::M_IDENT;
			end else if (char_code == ctss_pkg::CH_QUOTE) begin
				idle_mode = ctss_pkg::M_CHOPEN;
			end else if (is_pair_first(char_code)) begin
				idle_mode = ctss_pkg::M_PAIR;
			end else if (char_code == ctss_pkg::CH_SLASH) begin
				idle_mode = ctss_pkg::M_SLASH;
			end else begin
				idle_emit = 1'b1;
				idle_tok  = mk_tok(punct_kind(char_code), 64'(char_code), 4'd1, line_q, col_inc1);
				if (punct_kind(char_code) == ctss_pkg::TK_ERROR)
					idle_mode = ctss_pkg::M_HALTED;
			end
		end
	end

	always_comb begin
		mode_d = mode_q;
		buf_d  = buf_q;
		cnt_d  = cnt_q;
		line_d = line_q;
		col_d  = col_q;
		emit0  = 1'b0;
		rescan = 1'b0;
		tok0   = mk_tok(ctss_pkg::TK_END, '0, '0, line_q, col_q);
		unique case (mode_q)
			ctss_pkg::M_IDLE: begin
				rescan = 1'b1;
			end
			ctss_pkg::M_HALTED: begin
				emit0 = 1'b0;
			end
			ctss_pkg::M_ENDED: begin
				emit0 = 1'b1;
			end
			ctss_pkg::M_NUMBER: begin
				if (is_digit(char_code) || is_letter(char_code)) begin
					buf_d = buf_add;
					cnt_d = cnt_add;
					col_d = col_inc1;
					if (is_letter(char_code))
						mode_d = ctss_pkg::M_NUMBAD;
				end else begin
					emit0  = 1'b1;
					tok0   = mk_tok(ctss_pkg::TK_INT_CONST, cur_text, cnt_q, line_q, col_q);
					rescan = 1'b1;
				end
			end
			ctss_pkg::M_NUMBAD: begin
				if (char_code == ctss_pkg::CH_SPACE || char_code == ctss_pkg::CH_NL ||
					char_code == ctss_pkg::CH_NUL) begin
					emit0  = 1'b1;
					tok0   = mk_tok(ctss_pkg::TK_ERROR, cur_text, cnt_q, line_q, col_q);
					mode_d = ctss_pkg::M_HALTED;
				end else begin
					buf_d = buf_add;
					cnt_d = cnt_add;
					col_d = col_inc1;
				end
			end
			ctss_pkg::M_CHOPEN, ctss_pkg::M_CHESC: begin
				if (char_code == ctss_pkg::CH_NUL) begin
					emit0  = 1'b1;
					tok0   = mk_tok(ctss_pkg::TK_ERROR, cur_text, cnt_q, line_q, col_q);
					mode_d = ctss_pkg::M_HALTED;
				end else begin
					buf_d  = buf_add;
					cnt_d  = cnt_add;
					col_d  = col_inc1;
					mode_d = (mode_q == ctss_pkg::M_CHOPEN && char_code == ctss_pkg::CH_BSLASH) ?
						ctss_pkg::M_CHESC : ctss_pkg::M_CHCLOSE;
				end
			end
			ctss_pkg::M_CHCLOSE: begin
				emit0 = 1'b1;
				if (char_code == ctss_pkg::CH_QUOTE) begin
					col_d  = col_inc1;
					tok0   = mk_tok(ctss_pkg::TK_CHAR_CONST, cur_text, cnt_q, line_q, col_inc1);
					mode_d = ctss_pkg::M_IDLE;
				end else begin
					buf_d  = buf_drop;
					cnt_d  = cnt_drop;
					tok0   = mk_tok(ctss_pkg::TK_ERROR, 64'(buf_drop), cnt_drop, line_q, col_q);
					mode_d = ctss_pkg::M_HALTED;
				end
			end
			ctss_pkg::M_IDENT, ctss_pkg::M_IDLONG: begin
				if (is_digit(char_code) || is_letter(char_code) || char_code == ctss_pkg::CH_UNDER) begin
					buf_d = buf_add;
					cnt_d = cnt_add;
					col_d = col_inc1;
					if (!add_ok)
						mode_d = ctss_pkg::M_IDLONG;
				end else begin
					emit0  = 1'b1;
					tok0   = mk_tok((mode_q == ctss_pkg::M_IDENT) ? ident_kind(cur_text, cnt_q) :
						ctss_pkg::TK_IDENT, cur_text, cnt_q, line_q, col_q);
					rescan = 1'b1;
				end
			end
			ctss_pkg::M_PAIR: begin
				emit0 = 1'b1;
				if (char_code == pair_second) begin
					buf_d  = buf_add;
					cnt_d  = cnt_add;
					col_d  = col_inc1;
					tok0   = mk_tok(pair_kind(pair_first, 1'b1), 64'(buf_add), cnt_add, line_q,
						col_inc1);
					mode_d = ctss_pkg::M_IDLE;
				end else begin
					tok0   = mk_tok(pair_kind(pair_first, 1'b0), cur_text, cnt_q, line_q, col_q);
					rescan = 1'b1;
				end
			end
			ctss_pkg::M_SLASH: begin
				if (char_code == ctss_pkg::CH_SLASH) begin
					col_d  = col_inc1;
					buf_d  = '0;
					cnt_d  = 4'd0;
					mode_d = ctss_pkg::M_COMMENT;
				end else begin
					emit0  = 1'b1;
					tok0   = mk_tok(ctss_pkg::TK_SLASH, cur_text, cnt_q, line_q, col_q);
					rescan = 1'b1;
				end
			end
			ctss_pkg::M_COMMENT: begin
				if (char_code == ctss_pkg::CH_NUL) begin
					buf_d  = '0;
					cnt_d  = 4'd0;
					emit0  = 1'b1;
					mode_d = ctss_pkg::M_ENDED;
				end else if (char_code == ctss_pkg::CH_NL) begin
					rescan = 1'b1;
				end else begin
					col_d = col_inc1;
				end
			end
			default: begin
				rescan = 1'b1;
			end
		endcase
		if (rescan) begin
			mode_d = idle_mode;
			buf_d  = idle_buf;
			cnt_d  = idle_cnt;
			line_d = idle_line;
			col_d  = idle_col;
		end
	end

	assign push             = accept && (emit0 || (rescan && idle_emit));
	assign push_data.two    = emit0 && rescan && idle_emit;
	assign push_data.first  = emit0 ? tok0 : idle_tok;
	assign push_data.second = idle_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ctss_pkg::M_IDLE;
			buf_q  <= '0;
			cnt_q  <= 4'd0;
			line_q <= COUNTER_BITS'(1);
			col_q  <= COUNTER_BITS'(1);
		end else if (accept) begin
			mode_q <= mode_d;
			buf_q  <= buf_d;
			cnt_q  <= cnt_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		push && ((push_data.two ? push_data.second.kind : push_data.first.kind) ==
			ctss_pkg::TK_ERROR) |=> mode_q == ctss_pkg::M_HALTED)
		else $error("error token did not halt the scanner");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ctss_pkg::M_HALTED |-> !push)
		else $error("halted scanner produced a token");

endmodule

@@ hdl/ctss_queue.sv @@
// Short register queue of token bundles between the front and back ends.
module ctss_queue #(
	parameter int DEPTH = ctss_pkg::DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ctss_pkg::bundle_t push_data,
	output logic              full,
	input  logic              pop,
	output ctss_pkg::bundle_t pop_data,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ctss_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with an empty count");

endmodule

@@ hdl/ctss_back.sv @@
// Back end: takes bundles from the queue and hands out their tokens one per request.
module ctss_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  ctss_pkg::bundle_t q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [4:0]        token_kind,
	output logic [63:0]       lexeme_text,
	output logic [3:0]        lexeme_length,
	output logic [15:0]       line_number,
	output logic [15:0]       column_number,
	output logic              last_of_run
);

	ctss_pkg::bundle_t hold_q;
	ctss_pkg::token_t  cur;
	logic              hold_valid_q, phase_q, take, finish, load;

	assign take   = hold_valid_q && !out_stall;
	assign finish = take && (phase_q || !hold_q.two);
	assign load   = !q_empty && (!hold_valid_q || finish);
	assign pop    = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			phase_q      <= 1'b0;
		end else if (load) begin
			hold_valid_q <= 1'b1;
			phase_q      <= 1'b0;
		end else if (finish) begin
			hold_valid_q <= 1'b0;
			phase_q      <= 1'b0;
		end else if (take) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			hold_q <= q_data;
	end

	assign cur           = phase_q ? hold_q.second : hold_q.first;
	assign out_valid     = hold_valid_q;
	assign token_kind    = cur.kind;
	assign lexeme_text   = cur.text;
	assign lexeme_length = cur.len;
	assign line_number   = cur.line;
	assign column_number = cur.col;
	assign last_of_run   = phase_q || !hold_q.two;

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> hold_valid_q && hold_q.two)
		else $error("second token selected without a two-token bundle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q && out_stall |=> hold_valid_q && $stable(phase_q))
		else $error("token changed while stalled");

endmodule

@@ hdl/c_subset_token_scanner.sv @@
// Top level of the C subset token scanner: front end, bundle queue and back end.
//
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid, in_stall  | char_code
//  out     | from block| out_valid, out_stall| token_kind, lexeme_text, lexeme_length,
//          |           |                     | line_number, column_number, last_of_run
//
// One text byte is taken per cycle while the bundle queue has room; a byte yields zero,
// one or two tokens, which pass through the queue and the hold register of the back end.
// Tokens leave one per cycle while out_stall is low, so bytes that yield two tokens
// drain at half rate, limited by the single output port. in_stall rises only when the
// queue is full. Reset is asynchronous and takes effect at once: no clearing pass is needed.
module c_subset_token_scanner #(
	parameter int LEXEME_CHARS = ctss_pkg::DEF_LEXEME_CHARS,
	parameter int COUNTER_BITS = ctss_pkg::DEF_COUNTER_BITS,
	parameter int QUEUE_DEPTH  = ctss_pkg::DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [63:0] lexeme_text,
	output logic [3:0]  lexeme_length,
	output logic [15:0] line_number,
	output logic [15:0] column_number,
	output logic        last_of_run
);

	ctss_pkg::bundle_t push_data, pop_data;
	logic              push, full, pop, empty;

	ctss_front #(
		.LEXEME_CHARS(LEXEME_CHARS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.char_code(char_code),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	ctss_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	ctss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.lexeme_text  (lexeme_text),
		.lexeme_length(lexeme_length),
		.line_number  (line_number),
		.column_number(column_number),
		.last_of_run  (last_of_run)
	);

endmodule

@@ verif/c_subset_token_scanner_tb.sv @@
// Self-checking testbench that streams C-like text through the scanner and checks each token.
module c_subset_token_scanner_tb;

	localparam int LIMIT_TIME   = 2_400_000;
	localparam int RANDOM_BYTES = 1650;
	localparam int HOLD_START   = 800;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_START   = 1600;
	localparam int CALM_CYCLES  = 1000;
	localparam int QUIET_FROM   = 500;
	localparam int QUIET_TO     = 1100;
	localparam int DRAIN_CYCLES = 16;
	localparam int DRAIN_LIMIT  = 20000;

	localparam logic [7:0] PAIR_FIRST [6] = '{ctss_pkg::CH_GT, ctss_pkg::CH_LT,
		ctss_pkg::CH_EQUALS, ctss_pkg::CH_PLUS, ctss_pkg::CH_MINUS, ctss_pkg::CH_BANG};
	localparam logic [7:0] PUNCT [11] = '{ctss_pkg::CH_COMMA, ctss_pkg::CH_SEMI,
		ctss_pkg::CH_LPAREN, ctss_pkg::CH_RPAREN, ctss_pkg::CH_LBRACE, ctss_pkg::CH_RBRACE,
		ctss_pkg::CH_LBRACKET, ctss_pkg::CH_RBRACKET, ctss_pkg::CH_STAR, ctss_pkg::CH_SLASH,
		ctss_pkg::CH_PERCENT};
	localparam logic [7:0] BLANKS [3] = '{ctss_pkg::CH_SPACE, ctss_pkg::CH_TAB, ctss_pkg::CH_NL};

	class c_token_tracker;
		typedef logic [ctss_pkg::DEF_COUNTER_BITS-1:0] count_t;
		typedef struct packed {
			logic             last;
			ctss_pkg::token_t tok;
		} token_due_t;
		localparam count_t COUNT_MAX = '1;

		ctss_pkg::scan_mode_t mode;
		logic [63:0]          lex;
		int unsigned          lex_n;
		count_t               line;
		count_t               col;
		ctss_pkg::token_t     burst[$];
		token_due_t           tokens_due[$];
		int unsigned          checked;
		int unsigned          failures;

		function new();
			mode     = ctss_pkg::M_IDLE;
			lex      = '0;
			lex_n    = 0;
			line     = 1;
			col      = 1;
			checked  = 0;
			failures = 0;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= ctss_pkg::CH_DIGIT_0 && b <= ctss_pkg::CH_DIGIT_9;
		endfunction

		function bit is_letter(logic [7:0] b);
			return (b >= ctss_pkg::CH_LOWER_A && b <= ctss_pkg::CH_LOWER_Z) ||
				(b >= ctss_pkg::CH_UPPER_A && b <= ctss_pkg::CH_UPPER_Z);
		endfunction

		function void col_add(int unsigned n);
			if (COUNT_MAX - col < n)
				col = COUNT_MAX;
			else
				col = col + n;
		endfunction

		function void emit(logic [4:0] k, logic [63:0] t, int unsigned n);
			ctss_pkg::token_t tok;
			tok.kind = k;
			tok.text = t;
			tok.len  = n[3:0];
			tok.line = line[15:0];
			tok.col  = col[15:0];
			if (burst.size() < 2)
				burst.push_back(tok);
		endfunction

		function bit push_lex(logic [7:0] b);
			if (lex_n >= ctss_pkg::DEF_LEXEME_CHARS)
				return 1'b0;
			lex[8*lex_n +: 8] = b;
			lex_n++;
			return 1'b1;
		endfunction

		function logic [4:0] word_kind();
			if (lex_n == ctss_pkg::KW_SHORT_LEN && lex == ctss_pkg::KW_INT_TEXT)
				return ctss_pkg::TK_KW_INT;
			if (lex_n == ctss_pkg::KW_SHORT_LEN && lex == ctss_pkg::KW_FOR_TEXT)
				return ctss_pkg::TK_KW_FOR;
			if (lex_n == ctss_pkg::KW_LONG_LEN && lex == ctss_pkg::KW_DOUBLE_TEXT)
				return ctss_pkg::TK_KW_DOUBLE;
			if (lex_n == ctss_pkg::KW_LONG_LEN && lex == ctss_pkg::KW_RETURN_TEXT)
				return ctss_pkg::TK_KW_RETURN;
			return ctss_pkg::TK_IDENT;
		endfunction

		function logic [4:0] pair_code(logic [7:0] first, bit two);
			case (first)
				ctss_pkg::CH_GT: return two ? ctss_pkg::TK_GE : ctss_pkg::TK_GT;
				ctss_pkg::CH_LT: return two ? ctss_pkg::TK_LE : ctss_pkg::TK_LT;
				ctss_pkg::CH_EQUALS: return two ? ctss_pkg::TK_EQ : ctss_pkg::TK_ASSIGN;
				ctss_pkg::CH_PLUS: return two ? ctss_pkg::TK_INC : ctss_pkg::TK_PLUS;
				ctss_pkg::CH_MINUS: return two ? ctss_pkg::TK_DEC : ctss_pkg::TK_MINUS;
				default: return two ? ctss_pkg::TK_NE : ctss_pkg::TK_NOT;
			endcase
		endfunction

		// A byte seen between tokens: skip blanks or start a new lexeme.
		function void open_token(logic [7:0] b);
			mode = ctss_pkg::M_IDLE;
			if (b == ctss_pkg::CH_NUL) begin
				emit(ctss_pkg::TK_END, '0, 0);
				mode = ctss_pkg::M_ENDED;
				return;
			end
			if (b == ctss_pkg::CH_SPACE) begin
				col_add(1);
				return;
			end
			if (b == ctss_pkg::CH_TAB) begin
				col_add(8);
				return;
			end
			if (b == ctss_pkg::CH_NL) begin
				if (line != COUNT_MAX)
					line = line + 1'b1;
				col = '0;
				return;
			end
			lex   = '0;
			lex_n = 0;
			if (b != ctss_pkg::CH_QUOTE)
				void'(push_lex(b));
			col_add(1);
			if (is_digit(b))
				mode = ctss_pkg::M_NUMBER;
			else if (is_letter(b))
				mode = ctss_pkg::M_IDENT;
			else begin
				case (b)
					ctss_pkg::CH_QUOTE: mode = ctss_pkg::M_CHOPEN;
					ctss_pkg::CH_GT, ctss_pkg::CH_LT, ctss_pkg::CH_EQUALS, ctss_pkg::CH_PLUS,
					ctss_pkg::CH_MINUS, ctss_pkg::CH_BANG: mode = ctss_pkg::M_PAIR;
					ctss_pkg::CH_SLASH: mode = ctss_pkg::M_SLASH;
					ctss_pkg::CH_COMMA: emit(ctss_pkg::TK_COMMA, lex, lex_n);
					ctss_pkg::CH_SEMI: emit(ctss_pkg::TK_SEMI, lex, lex_n);
					ctss_pkg::CH_LPAREN: emit(ctss_pkg::TK_LPAREN, lex, lex_n);
					ctss_pkg::CH_RPAREN: emit(ctss_pkg::TK_RPAREN, lex, lex_n);
					ctss_pkg::CH_LBRACE: emit(ctss_pkg::TK_LBRACE, lex, lex_n);
					ctss_pkg::CH_RBRACE: emit(ctss_pkg::TK_RBRACE, lex, lex_n);
					ctss_pkg::CH_LBRACKET: emit(ctss_pkg::TK_LBRACKET, lex, lex_n);
					ctss_pkg::CH_RBRACKET: emit(ctss_pkg::TK_RBRACKET, lex, lex_n);
					ctss_pkg::CH_STAR: emit(ctss_pkg::TK_STAR, lex, lex_n);
					ctss_pkg::CH_PERCENT: emit(ctss_pkg::TK_PERCENT, lex, lex_n);
					default: begin
						emit(ctss_pkg::TK_ERROR, lex, lex_n);
						mode = ctss_pkg::M_HALTED;
					end
				endcase
			end
		endfunction

		function void note_char(logic [7:0] b);
			logic [7:0] first;
			token_due_t due;
			burst.delete();
			case (mode)
				ctss_pkg::M_HALTED: ;
				ctss_pkg::M_ENDED: emit(ctss_pkg::TK_END, '0, 0);
				ctss_pkg::M_NUMBER: begin
					if (is_digit(b)) begin
						void'(push_lex(b));
						col_add(1);
					end else if (is_letter(b)) begin
						void'(push_lex(b));
						col_add(1);
						mode = ctss_pkg::M_NUMBAD;
					end else begin
						emit(ctss_pkg::TK_INT_CONST, lex, lex_n);
						open_token(b);
					end
				end
				ctss_pkg::M_NUMBAD: begin
					if (b == ctss_pkg::CH_SPACE || b == ctss_pkg::CH_NL || b == ctss_pkg::CH_NUL) begin
						emit(ctss_pkg::TK_ERROR, lex, lex_n);
						mode = ctss_pkg::M_HALTED;
					end else begin
						void'(push_lex(b));
						col_add(1);
					end
				end
				ctss_pkg::M_CHOPEN, ctss_pkg::M_CHESC: begin
					if (b == ctss_pkg::CH_NUL) begin
						emit(ctss_pkg::TK_ERROR, lex, lex_n);
						mode = ctss_pkg::M_HALTED;
					end else begin
						void'(push_lex(b));
						col_add(1);
						mode = (mode == ctss_pkg::M_CHOPEN && b == ctss_pkg::CH_BSLASH) ?
							ctss_pkg::M_CHESC : ctss_pkg::M_CHCLOSE;
					end
				end
				ctss_pkg::M_CHCLOSE: begin
					if (b == ctss_pkg::CH_QUOTE) begin
						col_add(1);
						emit(ctss_pkg::TK_CHAR_CONST, lex, lex_n);
						mode = ctss_pkg::M_IDLE;
					end else begin
						// The unclosed constant loses its last byte.
						if (lex_n > 0) begin
							lex_n--;
							lex[8*lex_n +: 8] = '0;
						end
						emit(ctss_pkg::TK_ERROR, lex, lex_n);
						mode = ctss_pkg::M_HALTED;
					end
				end
				ctss_pkg::M_IDENT, ctss_pkg::M_IDLONG: begin
					if (is_digit(b) || is_letter(b) || b == ctss_pkg::CH_UNDER) begin
						if (!push_lex(b))
							mode = ctss_pkg::M_IDLONG;
						col_add(1);
					end else begin
						emit((mode == ctss_pkg::M_IDENT) ? word_kind() : ctss_pkg::TK_IDENT,
							lex, lex_n);
						open_token(b);
					end
				end
				ctss_pkg::M_PAIR: begin
					first = lex[7:0];
					if (b == ((first == ctss_pkg::CH_PLUS || first == ctss_pkg::CH_MINUS) ?
							first : ctss_pkg::CH_EQUALS)) begin
						void'(push_lex(b));
						col_add(1);
						emit(pair_code(first, 1'b1), lex, lex_n);
						mode = ctss_pkg::M_IDLE;
					end else begin
						emit(pair_code(first, 1'b0), lex, lex_n);
						open_token(b);
					end
				end
				ctss_pkg::M_SLASH: begin
					if (b == ctss_pkg::CH_SLASH) begin
						col_add(1);
						lex   = '0;
						lex_n = 0;
						mode  = ctss_pkg::M_COMMENT;
					end else begin
						emit(ctss_pkg::TK_SLASH, lex, lex_n);
						open_token(b);
					end
				end
				ctss_pkg::M_COMMENT: begin
					if (b == ctss_pkg::CH_NUL) begin
						lex   = '0;
						lex_n = 0;
						emit(ctss_pkg::TK_END, '0, 0);
						mode = ctss_pkg::M_ENDED;
					end else if (b == ctss_pkg::CH_NL)
						open_token(b);
					else
						col_add(1);
				end
				default: open_token(b);
			endcase
			foreach (burst[i]) begin
				due.tok  = burst[i];
				due.last = (i == burst.size() - 1);
				tokens_due.push_back(due);
			end
		endfunction

		function void check_token(ctss_pkg::token_t got, logic got_last);
			token_due_t want;
			checked++;
			if (tokens_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Unexpected token: kind %0d len %0d text %h line %0d col %0d",
						got.kind, got.len, got.text, got.line, got.col);
				return;
			end
			want = tokens_due.pop_front();
			if (got !== want.tok || got_last !== want.last) begin
				failures++;
				if (failures <= 10) begin
					$display("Token %0d differs: expected kind %0d len %0d text %h",
						checked, want.tok.kind, want.tok.len, want.tok.text);
					$display("  expected line %0d col %0d last %0b",
						want.tok.line, want.tok.col, want.last);
					$display("  got kind %0d len %0d text %h line %0d col %0d last %0b",
						got.kind, got.len, got.text, got.line, got.col, got_last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  token_kind;
	logic [63:0] lexeme_text;
	logic [3:0]  lexeme_length;
	logic [15:0] line_number;
	logic [15:0] column_number;
	logic        last_of_run;

	logic [7:0]     text_bytes[$];
	int unsigned    bytes_sent;
	int unsigned    held_cycles;
	int unsigned    rx_cycles;
	string          ending;
	c_token_tracker tracker;

	c_subset_token_scanner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.token_kind    (token_kind),
		.lexeme_text   (lexeme_text),
		.lexeme_length (lexeme_length),
		.line_number   (line_number),
		.column_number (column_number),
		.last_of_run   (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(LIMIT_TIME);
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(1) == 0)
			return ctss_pkg::CH_LOWER_A + 8'($urandom_range(25));
		return ctss_pkg::CH_UPPER_A + 8'($urandom_range(25));
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endtask

	// Well-formed text: no stray byte, no number running into a letter, no end of text.
	task automatic add_c_text(int unsigned n_bytes);
		int unsigned stop;
		int unsigned pick;
		int unsigned r;
		int unsigned n;
		bit          after_number;
		bit          after_slash;
		logic [7:0]  b;
		stop         = text_bytes.size() + n_bytes;
		after_number = 1'b0;
		after_slash  = 1'b0;
		while (text_bytes.size() < stop) begin
			pick = $urandom_range(99);
			b = (pick < 70) ? PAIR_FIRST[$urandom_range(5)] : PUNCT[$urandom_range(10)];
			if ((after_number && pick < 25) ||
					(after_slash && (pick >= 88 || (pick >= 70 && b == ctss_pkg::CH_SLASH))) ||
					$urandom_range(2) == 0) begin
				repeat ($urandom_range(1, 3))
					text_bytes.push_back(BLANKS[$urandom_range(2)]);
			end
			after_number = 1'b0;
			after_slash  = 1'b0;
			if (pick < 25) begin
				if ($urandom_range(4) == 0) begin
					case ($urandom_range(3))
						0: push_text("int");
						1: push_text("double");
						2: push_text("for");
						default: push_text("return");
					endcase
				end else begin
					n = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
					text_bytes.push_back(rand_letter());
					repeat (n - 1) begin
						r = $urandom_range(9);
						if (r < 6)
							text_bytes.push_back(rand_letter());
						else if (r < 9)
							text_bytes.push_back(ctss_pkg::CH_DIGIT_0 + 8'($urandom_range(9)));
						else
							text_bytes.push_back(ctss_pkg::CH_UNDER);
					end
				end
			end else if (pick < 40) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 5);
				repeat (n)
					text_bytes.push_back(ctss_pkg::CH_DIGIT_0 + 8'($urandom_range(9)));
				after_number = 1'b1;
			end else if (pick < 52) begin
				text_bytes.push_back(ctss_pkg::CH_QUOTE);
				if ($urandom_range(3) == 0) begin
					text_bytes.push_back(ctss_pkg::CH_BSLASH);
					b = 8'($urandom_range(1, 255));
				end else begin
					do b = 8'($urandom_range(1, 255)); while (b == ctss_pkg::CH_BSLASH);
				end
				text_bytes.push_back(b);
				text_bytes.push_back(ctss_pkg::CH_QUOTE);
			end else if (pick < 70) begin
				text_bytes.push_back(b);
				if ($urandom_range(1) == 0)
					text_bytes.push_back((b == ctss_pkg::CH_PLUS || b == ctss_pkg::CH_MINUS) ?
						b : ctss_pkg::CH_EQUALS);
			end else if (pick < 88) begin
				text_bytes.push_back(b);
				after_slash = (b == ctss_pkg::CH_SLASH);
			end else begin
				push_text("//");
				repeat ($urandom_range(10)) begin
					do b = 8'($urandom_range(1, 255)); while (b == ctss_pkg::CH_NL);
					text_bytes.push_back(b);
				end
				text_bytes.push_back(ctss_pkg::CH_NL);
			end
		end
		text_bytes.push_back(ctss_pkg::CH_NL);
	endtask

	task automatic send_text();
		foreach (text_bytes[i]) begin
			@(negedge clk);
			if (i < QUIET_FROM || i >= QUIET_TO) begin
				while ($urandom_range(99) < 12) begin
					in_valid <= 1'b0;
					@(negedge clk);
				end
			end
			in_valid  <= 1'b1;
			char_code <= text_bytes[i];
			@(posedge clk);
			while (in_stall) begin
				held_cycles++;
				@(posedge clk);
			end
			tracker.note_char(text_bytes[i]);
			bytes_sent++;
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_token({token_kind, lexeme_text, lexeme_length, line_number,
				column_number}, last_of_run);
	end

	// The receiver stalls at random, except for one long hold-off and one calm stretch.
	initial begin
		out_stall = 1'b0;
		rx_cycles = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles > HOLD_START && rx_cycles <= HOLD_START + HOLD_CYCLES)
				out_stall <= 1'b1;
			else if (rx_cycles > CALM_START && rx_cycles <= CALM_START + CALM_CYCLES)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < 12);
		end
	end

	initial begin
		logic [7:0]  b;
		int unsigned waited;
		tracker     = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_code   = '0;
		bytes_sent  = 0;
		held_cycles = 0;

		push_text("int double for return x_9 Zy_longidentifier 1234567890123;\n");
		push_text("'a' '\\n' '\\'' ''' ");
		text_bytes.push_back(ctss_pkg::CH_QUOTE);
		text_bytes.push_back(8'h01);
		text_bytes.push_back(ctss_pkg::CH_QUOTE);
		text_bytes.push_back(ctss_pkg::CH_QUOTE);
		text_bytes.push_back(ctss_pkg::CH_BSLASH);
		text_bytes.push_back(8'hFF);
		text_bytes.push_back(ctss_pkg::CH_QUOTE);
		push_text(" >= > <= < == = ++ + -- - != !\n,;(){}[]*/% a/b //");
		text_bytes.push_back(8'h80);
		text_bytes.push_back(8'hFF);
		push_text("\n\t\tx\n");

		add_c_text(RANDOM_BYTES);

		case ($urandom_range(5))
			0: begin
				ending = "a plain end of text";
				text_bytes.push_back(ctss_pkg::CH_NUL);
			end
			1: begin
				ending = "end of text inside a comment";
				push_text("// tail");
				text_bytes.push_back(ctss_pkg::CH_NUL);
			end
			2: begin
				ending = "a stray byte";
				do b = 8'($urandom_range(1, 255));
				while (b inside {ctss_pkg::CH_TAB, ctss_pkg::CH_NL, ctss_pkg::CH_SPACE,
					ctss_pkg::CH_BANG, ctss_pkg::CH_PERCENT, ctss_pkg::CH_QUOTE,
					[ctss_pkg::CH_LPAREN:ctss_pkg::CH_MINUS], ctss_pkg::CH_SLASH,
					[ctss_pkg::CH_DIGIT_0:ctss_pkg::CH_DIGIT_9],
					[ctss_pkg::CH_SEMI:ctss_pkg::CH_GT],
					[ctss_pkg::CH_UPPER_A:ctss_pkg::CH_UPPER_Z],
					[ctss_pkg::CH_LOWER_A:ctss_pkg::CH_LOWER_Z], ctss_pkg::CH_LBRACKET,
					ctss_pkg::CH_RBRACKET, ctss_pkg::CH_LBRACE, ctss_pkg::CH_RBRACE});
				text_bytes.push_back(b);
			end
			3: begin
				ending = "a number running into a letter";
				push_text("47");
				text_bytes.push_back(rand_letter());
				repeat ($urandom_range(1, 9)) begin
					do b = 8'($urandom_range(1, 255));
					while (b == ctss_pkg::CH_SPACE || b == ctss_pkg::CH_NL);
					text_bytes.push_back(b);
				end
				text_bytes.push_back(BLANKS[2 * $urandom_range(1)] & {8{$urandom_range(3) != 0}});
			end
			4: begin
				ending = "a char constant without its closing quote";
				text_bytes.push_back(ctss_pkg::CH_QUOTE);
				do b = 8'($urandom_range(1, 255)); while (b == ctss_pkg::CH_BSLASH);
				text_bytes.push_back(b);
				do b = 8'($urandom_range(0, 255)); while (b == ctss_pkg::CH_QUOTE);
				text_bytes.push_back(b);
			end
			default: begin
				ending = "end of text inside a char constant";
				text_bytes.push_back(ctss_pkg::CH_QUOTE);
				if ($urandom_range(1) == 0)
					text_bytes.push_back(ctss_pkg::CH_BSLASH);
				text_bytes.push_back(ctss_pkg::CH_NUL);
			end
		endcase
		repeat (4)
			text_bytes.push_back(8'($urandom_range(255)));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_text();
		waited = 0;
		while (tracker.tokens_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.tokens_due.size() != 0)
			$display("%0d expected tokens never arrived.", tracker.tokens_due.size());
		tracker.failures += tracker.tokens_due.size();

		$display("Scanned %0d text bytes into %0d tokens; the input was held back on %0d cycles.",
			bytes_sent, tracker.checked, held_cycles);
		$display("The text mixed keywords, constants, operators and comments and closed with %s.",
			ending);
		if (tracker.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/ctss_pkg.sv
hdl/ctss_front.sv
hdl/ctss_queue.sv
hdl/ctss_back.sv
hdl/c_subset_token_scanner.sv
verif/c_subset_token_scanner_tb.sv
